// ----- src/hcbp_pkg.sv -----
// ============================================================================
// hcbp_pkg
// shared widths, function codes and control structs of the code bit packer
// ============================================================================
`default_nettype none

package hcbp_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;
    localparam int LEFT_W   = 3;
    localparam int WIN_W    = BYTE_W + CODE_W;

    // table depth default and longest code kept in the table
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN     = 32;
    localparam int CAP_INT          = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_CODE = 1'b1;

    // packer commands
    typedef struct packed {
        logic merge;
        logic shift;
        logic clear;
    } t_pack_ctrl;

    // packer status
    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [PAD_W-1:0]  pend;
        logic [LEFT_W-1:0] left;
    } t_pack_stat;

endpackage

`default_nettype wire

// ----- src/hcbp_in_if.sv -----
// ============================================================================
// hcbp_in_if
// input channel: function, symbol and code fields with valid/ready
// ============================================================================
`default_nettype none

interface hcbp_in_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;

    modport source (output valid, output func, output symbol, output code_bits,
                    output code_len, input ready);
    modport sink   (input valid, input func, input symbol, input code_bits,
                    input code_len, output ready);
endinterface

`default_nettype wire

// ----- src/hcbp_out_if.sv -----
// ============================================================================
// hcbp_out_if
// result channel: packed byte, padding count and status with valid/ready
// ============================================================================
`default_nettype none

interface hcbp_out_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic [PAD_W-1:0]  pad_bits;
    logic              status;
    logic              last;

    modport source (output valid, output out_byte, output has_byte, output pad_bits,
                    output status, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input pad_bits,
                    input status, input last, output ready);
endinterface

`default_nettype wire

// ----- src/hcbp_code_table.sv -----
// ============================================================================
// hcbp_code_table
// per-symbol code memory with registered read and valid marks
// ============================================================================
`default_nettype none

module hcbp_code_table #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [hcbp_pkg::SYM_W-1:0]   i_wr_sym,
    input  wire logic [hcbp_pkg::CODE_W-1:0]  i_wr_code,
    input  wire logic [hcbp_pkg::LEN_W-1:0]   i_wr_len,
    input  wire logic                         i_rd_en,
    input  wire logic [hcbp_pkg::SYM_W-1:0]   i_rd_sym,
    output logic [hcbp_pkg::CODE_W-1:0]       o_rd_code,
    output logic [hcbp_pkg::LEN_W-1:0]        o_rd_len,
    output logic                              o_rd_hit
);
    import hcbp_pkg::*;

    localparam int IDX_W   = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam logic [SYM_W:0] SYM_LIM = (SYM_W + 1)'(SYMBOL_COUNT);

    logic [ENTRY_W-1:0]      r_mem [SYMBOL_COUNT];
    logic [ENTRY_W-1:0]      r_rd_data;
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_rd_hit;

    logic             w_wr_in;
    logic             w_rd_in;
    logic [IDX_W-1:0] w_wr_idx;
    logic [IDX_W-1:0] w_rd_idx;
    logic [LEN_W-1:0] w_len_sat;

    assign w_wr_in   = {1'b0, i_wr_sym} < SYM_LIM;
    assign w_rd_in   = {1'b0, i_rd_sym} < SYM_LIM;
    assign w_wr_idx  = i_wr_sym[IDX_W-1:0];
    assign w_rd_idx  = i_rd_sym[IDX_W-1:0];
    assign w_len_sat = (i_wr_len > LEN_CAP) ? LEN_CAP : i_wr_len;

    // code memory, write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_in) begin
            r_mem[w_wr_idx] <= {i_wr_code, w_len_sat};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    // valid marks and hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && w_wr_in) begin
                r_valid[w_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= w_rd_in && r_valid[w_rd_idx];
            end
        end
    end

    assign o_rd_code = r_rd_data[ENTRY_W-1:LEN_W];
    assign o_rd_len  = r_rd_data[LEN_W-1:0];
    assign o_rd_hit  = r_rd_hit;

`ifndef SYNTHESIS
    // one access per item, so the ports never overlap
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && i_rd_en))
        else $error("code table read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// ----- src/hcbp_packer.sv -----
// ============================================================================
// hcbp_packer
// msb-first bit window: clears, merges a code behind pending bits, pops whole bytes
// ============================================================================
`default_nettype none

module hcbp_packer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire hcbp_pkg::t_pack_ctrl         i_ctrl,
    input  wire logic [hcbp_pkg::CODE_W-1:0]  i_code,
    input  wire logic [hcbp_pkg::LEN_W-1:0]   i_len,
    output hcbp_pkg::t_pack_stat              o_stat
);
    import hcbp_pkg::*;

    logic [WIN_W-1:0]  r_win;
    logic [PAD_W-1:0]  r_pend;
    logic [LEFT_W-1:0] r_left;
    logic [WIN_W-1:0]  n_win;
    logic [PAD_W-1:0]  n_pend;
    logic [LEFT_W-1:0] n_left;

    logic [CODE_W-1:0] w_aligned;
    logic [WIN_W-1:0]  w_merged;
    logic [LEN_W-1:0]  w_total;

    // left-justify the code so its first bit sits at the top
    assign w_aligned = i_code << (LEN_W'(CODE_W) - i_len);
    assign w_merged  = {r_win[WIN_W-1:CODE_W], CODE_W'(0)}
                     | ({w_aligned, BYTE_W'(0)} >> r_pend);
    assign w_total   = LEN_W'(r_pend) + i_len;

    always_comb begin
        n_win  = r_win;
        n_pend = r_pend;
        n_left = r_left;
        if (i_ctrl.clear) begin
            n_win  = '0;
            n_pend = '0;
        end else if (i_ctrl.merge) begin
            n_win  = w_merged;
            n_left = w_total[LEN_W-1:PAD_W];
            n_pend = w_total[PAD_W-1:0];
        end else if (i_ctrl.shift) begin
            n_win  = r_win << BYTE_W;
            n_left = r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_pend <= '0;
            r_left <= '0;
        end else begin
            r_win  <= n_win;
            r_pend <= n_pend;
            r_left <= n_left;
        end
    end

    assign o_stat.head = r_win[WIN_W-1:CODE_W];
    assign o_stat.pend = r_pend;
    assign o_stat.left = r_left;

`ifndef SYNTHESIS
    // once all bytes are out, only the partial byte may hold bits
    a_tail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == '0) |-> (r_win[CODE_W-1:0] == '0))
        else $error("stale bits below the partial byte");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.shift && !i_ctrl.merge && !i_ctrl.clear) |-> (r_left != '0))
        else $error("byte popped with none complete");
`endif

endmodule

`default_nettype wire

// ----- src/huffman_code_bit_packer.sv -----
// ============================================================================
// huffman_code_bit_packer
// huffman encoder back end: per-symbol code table and msb-first byte packer
// ============================================================================
// One input transaction is handled at a time. A load writes the symbol's
// code (length saturated to 32) into the code table; it gives no result.
// An encode reads the table (synchronous read), merges the code behind the
// pending bits, then hands out one completed byte per cycle through the
// output register while that register is free (0 to 4 bytes per encode);
// an encode of an unloaded or out-of-range symbol gives a single
// status=1 result. A flush gives one result with the zero-padded partial
// byte and its padding count, or a result with no byte when no bits are
// pending. The rate is set by the table's read latency and by the single
// result register, which drains one byte per cycle while the receiver is
// ready. The result register lets the next input transaction be accepted
// while the last result still waits. Valid marks are flip-flops cleared by
// reset, so there is no clearing pass; code entries that were never loaded
// are never used.
// ============================================================================
`default_nettype none

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hcbp_in_if.sink    i_in,
    hcbp_out_if.source o_out
);
    import hcbp_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_EMIT   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_is_flush;
    logic   n_is_flush;

    // result register
    logic              r_out_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] n_out_byte;
    logic              r_out_has;
    logic              n_out_has;
    logic [PAD_W-1:0]  r_out_pad;
    logic [PAD_W-1:0]  n_out_pad;
    logic              r_out_status;
    logic              n_out_status;
    logic              r_out_last;
    logic              n_out_last;

    logic              w_in_acc;
    logic              w_slot_free;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [CODE_W-1:0] w_rd_code;
    logic [LEN_W-1:0]  w_rd_len;
    logic              w_rd_hit;
    t_pack_ctrl        w_pack_ctrl;
    t_pack_stat        w_pack_stat;

    // new work only while idle and out of reset
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    // result register can take a value this cycle
    assign w_slot_free = !r_out_valid || o_out.ready;

    hcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_sym  (i_in.symbol),
        .i_wr_code (i_in.code_bits),
        .i_wr_len  (i_in.code_len),
        .i_rd_en   (w_rd_en),
        .i_rd_sym  (i_in.symbol),
        .o_rd_code (w_rd_code),
        .o_rd_len  (w_rd_len),
        .o_rd_hit  (w_rd_hit)
    );

    hcbp_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pack_ctrl),
        .i_code  (w_rd_code),
        .i_len   (w_rd_len),
        .o_stat  (w_pack_stat)
    );

    always_comb begin
        n_state      = r_state;
        n_is_flush   = r_is_flush;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_has    = r_out_has;
        n_out_pad    = r_out_pad;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_pack_ctrl  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        FUNC_LOAD: begin
                            w_wr_en = 1'b1;
                        end
                        FUNC_ENCODE: begin
                            w_rd_en = 1'b1;
                            n_state = S_LOOKUP;
                        end
                        FUNC_FLUSH: begin
                            n_is_flush = 1'b1;
                            n_state    = S_RESULT;
                        end
                        default: begin
                            // unused code, dropped
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                // table data is valid this cycle
                if (w_rd_hit) begin
                    w_pack_ctrl.merge = 1'b1;
                    n_state           = S_EMIT;
                end else begin
                    n_is_flush = 1'b0;
                    n_state    = S_RESULT;
                end
            end
            S_EMIT: begin
                if (w_pack_stat.left == '0) begin
                    // no byte completed
                    n_state = S_IDLE;
                end else if (w_slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out_byte        = w_pack_stat.head;
                    n_out_has         = 1'b1;
                    n_out_pad         = '0;
                    n_out_status      = STATUS_OK;
                    n_out_last        = (w_pack_stat.left == LEFT_W'(1));
                    w_pack_ctrl.shift = 1'b1;
                    if (w_pack_stat.left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESULT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_is_flush) begin
                        // partial byte with zero padding, or an empty marker
                        n_out_has         = (w_pack_stat.pend != '0);
                        n_out_byte        = n_out_has ? w_pack_stat.head : '0;
                        n_out_pad         = n_out_has
                                          ? PAD_W'((PAD_W + 1)'(BYTE_W)
                                                   - {1'b0, w_pack_stat.pend})
                                          : '0;
                        n_out_status      = STATUS_OK;
                        w_pack_ctrl.clear = 1'b1;
                    end else begin
                        // symbol without a loaded code
                        n_out_has    = 1'b0;
                        n_out_byte   = '0;
                        n_out_pad    = '0;
                        n_out_status = STATUS_NO_CODE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_flush  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_flush  <= n_is_flush;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_has    <= n_out_has;
        r_out_pad    <= n_out_pad;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.has_byte = r_out_has;
    assign o_out.pad_bits = r_out_pad;
    assign o_out.status   = r_out_status;
    assign o_out.last     = r_out_last;

`ifndef SYNTHESIS
    // an error result carries no byte and closes its transaction
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STATUS_NO_CODE)) |-> (!r_out_has && r_out_last))
        else $error("error result with byte or without last");

    // an accepted encode goes straight to the table lookup
    a_encode_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.func == FUNC_ENCODE)) |=> (r_state == S_LOOKUP))
        else $error("encode transaction did not start a lookup");
`endif

endmodule

`default_nettype wire
